// ===== design/lpd_pkg.sv =====
// shared constants, state codes and control struct for the lidar packet deframer
// no dependencies
`default_nettype none

package lpd_pkg;

  // packet layout
  localparam int PACKET_BYTES     = 47;
  localparam int MAX_POINTS       = 12;
  localparam int FIRST_POINT_BYTE = 6;
  localparam int FIT_POINTS       = (PACKET_BYTES - FIRST_POINT_BYTE) / 3;
  localparam int PT_LIMIT         = (MAX_POINTS < FIT_POINTS) ? MAX_POINTS : FIT_POINTS;

  localparam int POS_W  = 6;
  localparam int CNT_W  = $clog2(PT_LIMIT + 1);
  localparam int IDX_W  = $clog2(FIT_POINTS + 1);
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  localparam int ANGLE_W = 16;
  localparam int SUM_W   = 18;
  localparam int OUT_ANGLE_W = 17;

  localparam logic [7:0]  HEADER_RESET   = 8'd84;
  localparam logic [7:0]  STEP_RESET     = 8'd80;
  localparam logic [15:0] ROTATION_RESET = 16'd36000;

  // configuration register indexes
  localparam logic [1:0] REG_HEADER   = 2'd0;
  localparam logic [1:0] REG_STEP     = 2'd1;
  localparam logic [1:0] REG_ROTATION = 2'd2;

  typedef enum logic [4:0] {
    S_RX    = 5'b00001,
    S_DELTA = 5'b00010,
    S_SUM   = 5'b00100,
    S_READ  = 5'b01000,
    S_LOAD  = 5'b10000
  } lpd_state_e;

  typedef struct packed {
    logic delta;  // latch start angle, form wrapped delta
    logic sum;    // accumulate and test for full turn
  } lpd_rot_ctl_t;

endpackage

`default_nettype wire

// ===== design/lidar_packet_deframer_unit.sv =====
// Lidar packet deframer. Takes one received byte per item, hunts for the header
// byte and collects the rest of a 47-byte packet; points are kept in a 12-entry
// synchronous memory (distance and intensity per entry, written once per point).
// On the last byte the rotation is tracked in the delta and sum states; then either
// one scan-done item is sent, or every point is read back from the memory and sent
// (read state, then load of the output register, per point), or, with no points
// and no full turn, nothing is sent. Bytes are taken one per cycle while a packet
// is being gathered; input stalls from the last byte of a packet until its results
// are all in the output register, and through any output stall.
// Depends on lpd_pkg and lpd_rotation.
`default_nettype none

module lidar_packet_deframer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             scan_done_o,
  output logic [16:0]      point_angle_o,
  output logic [15:0]      point_distance_o,
  output logic [7:0]       point_intensity_o,
  output logic             last_of_packet_o
);
  import lpd_pkg::*;

  logic [7:0]  header_q;
  logic [7:0]  step_q;
  logic [15:0] rotation_q;

  lpd_state_e state_q, state_d;

  logic               hunting_q;
  logic [POS_W-1:0]   pos_q;
  logic [1:0]         part_q;
  logic [IDX_W-1:0]   idx_q;
  logic [15:0]        asm_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [ANGLE_W-1:0] start_q;

  logic [CNT_W-1:0]       rd_idx_q;
  logic [OUT_ANGLE_W-1:0] ang_q;
  logic                   done_q;

  logic [23:0] mem [MAX_POINTS];
  logic [23:0] rdata_q;

  logic             in_acc;
  logic             out_free;
  logic             last_byte;
  logic             mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [4:0]       raw_cnt;
  logic             rd_last;
  logic             complete;
  lpd_rot_ctl_t     rot_ctl;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_RX);
  assign in_acc      = in_valid_i && (state_q == S_RX);
  assign out_free    = !out_valid_o || !out_stall_i;
  assign last_byte   = !hunting_q && (pos_q == POS_W'(PACKET_BYTES - 1));
  assign raw_cnt     = rx_byte_i[4:0];
  assign rd_last     = ((CNT_W+1)'(rd_idx_q) + 1'b1) == (CNT_W+1)'(cnt_q);

  assign mem_we  = in_acc && !hunting_q && (pos_q >= POS_W'(FIRST_POINT_BYTE))
                   && (part_q == 2'd2) && (6'(idx_q) < 6'(MAX_POINTS));
  assign wr_addr = ADDR_W'(idx_q);

  assign rot_ctl.delta = (state_q == S_DELTA);
  assign rot_ctl.sum   = (state_q == S_SUM);

  lpd_rotation u_rotation (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (rot_ctl),
    .pkt_angle_i    (start_q),
    .full_rotation_i(rotation_q),
    .complete_o     (complete)
  );

  // point memory: distance in low 16 bits, intensity above
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= {rx_byte_i, asm_q};
    end
    rdata_q <= mem[ADDR_W'(rd_idx_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q   <= HEADER_RESET;
      step_q     <= STEP_RESET;
      rotation_q <= ROTATION_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HEADER:   header_q   <= cfg_data_i[7:0];
        REG_STEP:     step_q     <= cfg_data_i[7:0];
        REG_ROTATION: rotation_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_RX: begin
        if (in_acc && last_byte) state_d = S_DELTA;
      end
      S_DELTA: state_d = S_SUM;
      S_SUM: begin
        if (complete) begin
          state_d = S_LOAD;
        end else if (cnt_q != '0) begin
          state_d = S_READ;
        end else begin
          state_d = S_RX;
        end
      end
      S_READ: state_d = S_LOAD;
      S_LOAD: begin
        if (out_free) begin
          state_d = (done_q || rd_last) ? S_RX : S_READ;
        end
      end
      default: state_d = S_RX;
    endcase
  end

  // byte gathering, state register and read-back index and angle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_RX;
      hunting_q <= 1'b1;
      pos_q     <= '0;
      part_q    <= '0;
      idx_q     <= '0;
      cnt_q     <= '0;
      start_q   <= '0;
      rd_idx_q  <= '0;
      ang_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (hunting_q) begin
          if (rx_byte_i == header_q) begin
            hunting_q <= 1'b0;
            pos_q     <= POS_W'(1);
          end
        end else begin
          if (pos_q == POS_W'(1)) begin
            cnt_q <= (raw_cnt > 5'(PT_LIMIT)) ? CNT_W'(PT_LIMIT) : CNT_W'(raw_cnt);
          end
          if (pos_q == POS_W'(4)) start_q[7:0]  <= rx_byte_i;
          if (pos_q == POS_W'(5)) begin
            start_q[15:8] <= rx_byte_i;
            part_q        <= '0;
            idx_q         <= '0;
          end
          if (pos_q >= POS_W'(FIRST_POINT_BYTE)) begin
            if (part_q == 2'd2) begin
              part_q <= '0;
              idx_q  <= idx_q + 1'b1;
            end else begin
              part_q <= part_q + 1'b1;
            end
          end
          if (last_byte) begin
            hunting_q <= 1'b1;
            pos_q     <= '0;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
      end
      if (state_q == S_SUM) begin
        done_q   <= complete;
        rd_idx_q <= '0;
        ang_q    <= OUT_ANGLE_W'(start_q);
      end
      if ((state_q == S_LOAD) && out_free && !done_q && !rd_last) begin
        rd_idx_q <= rd_idx_q + 1'b1;
        ang_q    <= ang_q + OUT_ANGLE_W'(step_q);
      end
    end
  end

  // distance bytes gathered before the intensity byte completes the entry
  always_ff @(posedge clk_i) begin
    if (in_acc && !hunting_q && (pos_q >= POS_W'(FIRST_POINT_BYTE))) begin
      if (part_q == 2'd0) asm_q[7:0]  <= rx_byte_i;
      if (part_q == 2'd1) asm_q[15:8] <= rx_byte_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((state_q == S_LOAD) && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_LOAD) && out_free) begin
      if (done_q) begin
        scan_done_o       <= 1'b1;
        point_angle_o     <= '0;
        point_distance_o  <= '0;
        point_intensity_o <= '0;
        last_of_packet_o  <= 1'b1;
      end else begin
        scan_done_o       <= 1'b0;
        point_angle_o     <= ang_q;
        point_distance_o  <= rdata_q[15:0];
        point_intensity_o <= rdata_q[23:16];
        last_of_packet_o  <= rd_last;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/lpd_rotation.sv =====
// rotation tracker: previous start angle, accumulated turn and first-of-scan flag
// depends on lpd_pkg
`default_nettype none

module lpd_rotation (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lpd_pkg::lpd_rot_ctl_t         ctl_i,
  input  wire logic [lpd_pkg::ANGLE_W-1:0]   pkt_angle_i,
  input  wire logic [15:0]                   full_rotation_i,
  output logic                               complete_o
);
  import lpd_pkg::*;

  logic [ANGLE_W-1:0] prev_q;
  logic [ANGLE_W-1:0] delta_q;
  logic [SUM_W-1:0]   sum_q;
  logic               first_q;
  logic               skip_q;

  logic [ANGLE_W-1:0] back;
  logic [ANGLE_W-1:0] delta_d;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_d;

  always_comb begin
    back = prev_q - pkt_angle_i;
    if (pkt_angle_i >= prev_q) begin
      delta_d = pkt_angle_i - prev_q;
    end else if (full_rotation_i > back) begin
      delta_d = full_rotation_i - back;
    end else begin
      delta_d = '0;
    end
  end

  // saturating accumulate
  always_comb begin
    sum_wide = {1'b0, sum_q} + (SUM_W+1)'(delta_q);
    sum_d    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  end

  assign complete_o = !skip_q && (sum_d >= SUM_W'(full_rotation_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      delta_q <= '0;
      sum_q   <= '0;
      first_q <= 1'b1;
      skip_q  <= 1'b0;
    end else begin
      if (ctl_i.delta) begin
        prev_q  <= pkt_angle_i;
        delta_q <= delta_d;
        skip_q  <= first_q;
        first_q <= 1'b0;
      end
      if (ctl_i.sum && !skip_q) begin
        if (complete_o) begin
          sum_q   <= '0;
          first_q <= 1'b1;
        end else begin
          sum_q <= sum_d;
        end
      end
    end
  end

endmodule

`default_nettype wire
